FILE: src/fka_pkg.sv
package fka_pkg;
    localparam int Capacity = 64;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = IdxW + 1;
    localparam logic [0:0] KIND_ADD = 1'b0;
    localparam logic [0:0] KIND_DUMP = 1'b1;
    localparam logic [0:0] REG_KEEP = 1'b0;
    localparam logic [0:0] REG_THRESH = 1'b1;
    localparam logic [5:0] KEEP_RESET = 6'd8;
    localparam logic [5:0] THRESH_RESET = 6'd16;
    typedef logic [IdxW-1:0] idx_t;
    typedef logic [CntW-1:0] cnt_t;
endpackage

FILE: src/frequent_key_accumulator_top.sv
// Frequent-key accumulator. Start is taken while busy is low, and busy stays high until the
// item is finished. An add walks the stored keys through the key memory one key at a time.
// A miss that prunes, and a dump of a non-empty table, first runs an insertion sort over the
// list order through the order and total memories. Each outer step fetches one entry and
// compares it with the entries before it. A prune then copies each kept entry through a
// holding memory before the append. A dump emits its results one at a time on out_valid,
// and the receiver cannot stall results. An empty dump gives one result with table_empty
// and last set.
module frequent_key_accumulator_top
    import fka_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [31:0] item_key,
    input  logic [31:0] amount,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    output logic [31:0] out_key,
    output logic [31:0] out_total,
    output logic        table_empty,
    output logic        last
);
    localparam logic [4:0] S_IDLE = 5'd0, S_SRCH = 5'd1, S_SCHK = 5'd2,
        S_UPD = 5'd3, S_APP = 5'd4, S_SOI = 5'd5, S_SOR = 5'd6,
        S_SOC = 5'd7, S_CPR = 5'd8, S_CPW = 5'd9, S_DMR = 5'd10,
        S_DMO = 5'd11, S_EMP = 5'd12, S_ORR = 5'd13, S_SOT = 5'd14,
        S_SOF = 5'd15, S_CPA = 5'd16;

    logic [31:0] key_mem [Capacity];
    logic [31:0] tot_mem [Capacity];
    idx_t        ord_mem [Capacity];

    logic [4:0]  state_reg;
    logic        kind_reg;
    logic [31:0] key_reg, amt_reg;
    cnt_t        cnt_reg, i_reg, j_reg;
    idx_t        slot_reg;
    logic [31:0] t_reg;
    logic [5:0]  keep_reg, thresh_reg;
    logic        ov_reg, emp_reg, last_reg;
    logic [31:0] okey_reg, otot_reg;

    // Memory ports: one write and one registered read each.
    logic        kwe, twe, owe;
    idx_t        kwa, twa, owa, kra, tra, ora;
    logic [31:0] kwd, twd, krd, trd;
    idx_t        owd, ord_q;

    always_ff @(posedge clk)
    begin
        if (kwe)
        begin
            key_mem[kwa] <= kwd;
        end
        if (twe)
        begin
            tot_mem[twa] <= twd;
        end
        if (owe)
        begin
            ord_mem[owa] <= owd;
        end
        krd <= key_mem[kra];
        trd <= tot_mem[tra];
        ord_q <= ord_mem[ora];
    end

    // A prune first gathers the kept entries in sorted order into a holding memory,
    // then writes them back to the lowest slots.
    logic [31:0] ck_mem [Capacity];
    logic [31:0] ct_mem [Capacity];
    logic [31:0] ckd, ctd;

    cnt_t n_keep;
    cnt_t im1, ip1, jm1, jm2;
    assign n_keep = (cnt_reg < cnt_t'(keep_reg)) ? cnt_reg : cnt_t'(keep_reg);
    assign im1 = i_reg - cnt_t'(1);
    assign ip1 = i_reg + cnt_t'(1);
    assign jm1 = j_reg - cnt_t'(1);
    assign jm2 = j_reg - cnt_t'(2);
    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign out_key = okey_reg;
    assign out_total = otot_reg;
    assign table_empty = emp_reg;
    assign last = last_reg;

    always_comb
    begin
        kwe = 1'b0; twe = 1'b0; owe = 1'b0;
        kwa = slot_reg; twa = slot_reg; owa = j_reg[IdxW-1:0];
        kwd = key_reg; twd = amt_reg; owd = slot_reg;
        kra = i_reg[IdxW-1:0]; tra = i_reg[IdxW-1:0]; ora = i_reg[IdxW-1:0];
        case (state_reg)
            S_SCHK:
            begin
                tra = slot_reg;
            end
            S_UPD:
            begin
                twe = 1'b1; twa = slot_reg; twd = trd + amt_reg;
            end
            S_APP:
            begin
                if (cnt_reg != cnt_t'(Capacity))
                begin
                    kwe = 1'b1; twe = 1'b1; owe = 1'b1;
                    kwa = cnt_reg[IdxW-1:0]; twa = cnt_reg[IdxW-1:0];
                    owa = cnt_reg[IdxW-1:0]; owd = cnt_reg[IdxW-1:0];
                end
            end
            S_SOI:
            begin
                tra = ord_q;
            end
            S_SOR:
            begin
                ora = jm1[IdxW-1:0];
            end
            S_SOF:
            begin
                ora = jm1[IdxW-1:0];
                tra = ord_q;
            end
            S_SOC:
            begin
                owe = 1'b1; owa = j_reg[IdxW-1:0];
                if (j_reg != '0 && trd < t_reg)
                begin
                    owd = ord_q;
                    ora = jm2[IdxW-1:0];
                end
                else
                begin
                    owd = slot_reg;
                end
            end
            S_CPR, S_DMR:
            begin
                kra = ord_q; tra = ord_q;
            end
            S_CPW:
            begin
                kwe = 1'b1; twe = 1'b1; owe = 1'b1;
                kwa = i_reg[IdxW-1:0]; twa = i_reg[IdxW-1:0];
                owa = i_reg[IdxW-1:0]; owd = i_reg[IdxW-1:0];
                kwd = ckd; twd = ctd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ORR && kind_reg == KIND_ADD && i_reg != '0)
        begin
            ck_mem[im1[IdxW-1:0]] <= krd;
            ct_mem[im1[IdxW-1:0]] <= trd;
        end
        ckd <= ck_mem[i_reg[IdxW-1:0]];
        ctd <= ct_mem[i_reg[IdxW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            keep_reg <= KEEP_RESET;
            thresh_reg <= THRESH_RESET;
            ov_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            kind_reg <= KIND_ADD;
            key_reg <= '0;
            amt_reg <= '0;
            slot_reg <= '0;
            t_reg <= '0;
            okey_reg <= '0;
            otot_reg <= '0;
            emp_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == REG_KEEP)
                begin
                    keep_reg <= cfg_data[5:0];
                end
                else
                begin
                    thresh_reg <= cfg_data[5:0];
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= kind;
                        key_reg <= item_key;
                        amt_reg <= amount;
                        i_reg <= '0;
                        if (kind == KIND_DUMP)
                        begin
                            if (cnt_reg == '0)
                            begin
                                state_reg <= S_EMP;
                            end
                            else
                            begin
                                i_reg <= cnt_t'(1);
                                state_reg <= S_SOT;
                            end
                        end
                        else
                        begin
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH:
                begin
                    if (i_reg >= cnt_reg)
                    begin
                        if (cnt_reg > cnt_t'(thresh_reg))
                        begin
                            i_reg <= cnt_t'(1);
                            state_reg <= S_SOT;
                        end
                        else
                        begin
                            state_reg <= S_APP;
                        end
                    end
                    else
                    begin
                        slot_reg <= i_reg[IdxW-1:0];
                        i_reg <= ip1;
                        state_reg <= S_SCHK;
                    end
                end
                S_SCHK:
                begin
                    if (krd == key_reg)
                    begin
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        state_reg <= S_SRCH;
                    end
                end
                S_UPD:
                begin
                    state_reg <= S_IDLE;
                end
                S_APP:
                begin
                    if (cnt_reg != cnt_t'(Capacity))
                    begin
                        cnt_reg <= cnt_reg + cnt_t'(1);
                    end
                    state_reg <= S_IDLE;
                end
                S_SOT:
                begin
                    // Outer sort step: fetch list_order[i].
                    if (i_reg >= cnt_reg)
                    begin
                        i_reg <= '0;
                        state_reg <= S_ORR;
                    end
                    else
                    begin
                        j_reg <= i_reg;
                        state_reg <= S_SOI;
                    end
                end
                S_SOI:
                begin
                    slot_reg <= ord_q;
                    state_reg <= S_SOR;
                end
                S_SOR:
                begin
                    t_reg <= trd;
                    state_reg <= S_SOF;
                end
                S_SOF:
                begin
                    state_reg <= S_SOC;
                end
                S_SOC:
                begin
                    if (j_reg != '0 && trd < t_reg)
                    begin
                        j_reg <= jm1;
                        state_reg <= (jm1 == '0) ? S_SOC : S_SOF;
                    end
                    else
                    begin
                        i_reg <= ip1;
                        state_reg <= S_SOT;
                    end
                end
                S_ORR:
                begin
                    if (kind_reg == KIND_DUMP)
                    begin
                        state_reg <= S_DMR;
                    end
                    else if (i_reg >= n_keep)
                    begin
                        i_reg <= '0;
                        if (n_keep == '0)
                        begin
                            cnt_reg <= '0;
                            state_reg <= S_APP;
                        end
                        else
                        begin
                            state_reg <= S_CPA;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CPR;
                    end
                end
                S_CPR:
                begin
                    i_reg <= ip1;
                    state_reg <= S_ORR;
                end
                S_CPA:
                begin
                    state_reg <= S_CPW;
                end
                S_CPW:
                begin
                    if (ip1 >= n_keep)
                    begin
                        cnt_reg <= n_keep;
                        state_reg <= S_APP;
                    end
                    else
                    begin
                        state_reg <= S_CPA;
                    end
                    i_reg <= ip1;
                end
                S_DMR:
                begin
                    state_reg <= S_DMO;
                end
                S_DMO:
                begin
                    ov_reg <= 1'b1;
                    okey_reg <= krd;
                    otot_reg <= trd;
                    emp_reg <= 1'b0;
                    last_reg <= (ip1 >= cnt_reg);
                    i_reg <= ip1;
                    state_reg <= (ip1 >= cnt_reg) ? S_IDLE : S_ORR;
                end
                S_EMP:
                begin
                    ov_reg <= 1'b1;
                    okey_reg <= '0;
                    otot_reg <= '0;
                    emp_reg <= 1'b1;
                    last_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy || last)
        else $error("result outside a dump");
    assert property (@(posedge clk) disable iff (!rst_n) table_empty && out_valid |-> last)
        else $error("empty result without last");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= cnt_t'(Capacity))
        else $error("entry count overflow");
endmodule
